// ===== hw/rtl/lek_pkg.sv =====
// Shared types and constants for the line editor with erase and kill.
// Used by the line editor top level and the checker; depends on nothing.
package lek_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CharW-1:0] NewlineCode = 8'd10;
  localparam logic [CharW-1:0] EraseReset  = 8'd35;  // '#'
  localparam logic [CharW-1:0] KillReset   = 8'd64;  // '@'

  localparam logic [CfgIdxW-1:0] CfgEraseIdx = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKillIdx  = 2'd1;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_end;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             out_last;
    logic             out_truncated;
  } out_item_t;

endpackage

// ===== hw/rtl/lek_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module lek_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/line_editor_erase_kill.sv =====
// Line editor top level: control FSM around the line store RAM.
// Depends on lek_pkg and lek_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i) takes one character or
//   an end mark per item. Ordinary characters, erase and kill leave the block
//   ready for the next item. A newline or end mark drains the stored characters
//   of the line oldest first on the output channel
//   (out_valid_o/out_ready_i, out_item_o): one character per cycle while the
//   receiver does not stall, set by the single read port of the line store.
//   The first character appears once the FSM has entered the drain state and
//   the RAM read register has been loaded. An empty line gives no items.
//   The RAM read register is the output register; a stalled receiver freezes
//   the read pointer and the shown item. Input is taken again once the last
//   character has been read, while that item may still wait at the output.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes erase_char (0) or
//   kill_char (1); other indexes are ignored.
//   Reset empties the line, clears the truncation flag and restores the
//   erase and kill codes to '#' and '@'. The store needs no clearing pass.
module line_editor_erase_kill
  import lek_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CharW-1:0]   cfg_data_i
);

  localparam int unsigned AddrW = $clog2(LINE_DEPTH);
  localparam int unsigned CntW  = $clog2(LINE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(LINE_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;
  logic             out_trunc_q, out_trunc_d;
  logic [CharW-1:0] erase_q, erase_d;
  logic [CharW-1:0] kill_q, kill_d;

  logic             in_fire;
  logic             is_flush, is_erase, is_kill;
  logic             wr_en, rd_en, advance, last_rd;
  logic [CharW-1:0] rd_data;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_flush   = in_item_i.in_end || (in_item_i.in_char == NewlineCode);
  assign is_erase   = in_item_i.in_char == erase_q;
  assign is_kill    = in_item_i.in_char == kill_q;
  assign advance    = !out_valid_q || out_ready_i;
  assign last_rd    = (CntW'(rd_ptr_q) + CntW'(1)) == fill_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    rd_ptr_d    = rd_ptr_q;
    out_last_d  = out_last_q;
    out_trunc_d = out_trunc_q;
    erase_d     = erase_q;
    kill_d      = kill_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEraseIdx: erase_d = cfg_data_i;
        CfgKillIdx:  kill_d  = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_flush) begin
            if (fill_q == '0) begin
              ovf_d = 1'b0;
            end else begin
              state_d  = ST_DRAIN;
              rd_ptr_d = '0;
            end
          end else if (is_erase) begin
            if (fill_q != '0) begin
              fill_d = fill_q - CntW'(1);
            end
          end else if (is_kill) begin
            fill_d = '0;
            ovf_d  = 1'b0;
          end else if (fill_q == FullCnt) begin
            ovf_d = 1'b1;
          end else begin
            wr_en  = 1'b1;
            fill_d = fill_q + CntW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (advance) begin
          rd_en       = 1'b1;
          rd_ptr_d    = rd_ptr_q + AddrW'(1);
          out_last_d  = last_rd;
          out_trunc_d = ovf_q;
          if (last_rd) begin
            state_d = ST_IDLE;
            fill_d  = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (rd_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
      erase_q     <= EraseReset;
      kill_q      <= KillReset;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
      erase_q     <= erase_d;
      kill_q      <= kill_d;
    end
  end

  // flags travel with the RAM read register
  always_ff @(posedge clk_i) begin
    out_last_q  <= out_last_d;
    out_trunc_q <= out_trunc_d;
  end

  lek_ram #(
    .Width(CharW),
    .Depth(LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(fill_q[AddrW-1:0]),
    .wdata_i(in_item_i.in_char),
    .re_i   (rd_en),
    .raddr_i(rd_ptr_q),
    .rdata_o(rd_data)
  );

  assign out_valid_o              = out_valid_q;
  assign out_item_o.out_char      = rd_data;
  assign out_item_o.out_last      = out_last_q;
  assign out_item_o.out_truncated = out_trunc_q;

endmodule

// ===== hw/rtl/lek_checker.sv =====
// Port-level checker for the line editor, bound to the top level.
// Depends on lek_pkg.
module lek_checker
  import lek_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input in_item_t           in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_item_t          out_item_o,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i,
  input logic [CharW-1:0]   cfg_data_i
);

  logic unused_ok;
  assign unused_ok = ^{in_valid_i, in_item_i, cfg_we_i, cfg_idx_i, cfg_data_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  // no new input while a line is partway out
  a_no_input_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.out_last |-> !in_ready_o)
    else $error("input ready in the middle of a line");

  // characters of one line follow back to back with one truncation flag
  a_line_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.out_last |=>
      out_valid_o && (out_item_o.out_truncated == $past(out_item_o.out_truncated)))
    else $error("line output broken or truncation flag changed");

endmodule

bind line_editor_erase_kill lek_checker u_lek_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_editor_erase_kill: queued characters, a line predictor
// and an output checker. Depends on lek_pkg and the line editor RTL.
module tb;
  import lek_pkg::*;

  localparam int unsigned LineDepth = 64;
  localparam int unsigned Limit = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam logic [CfgIdxW-1:0] UnusedIdx = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CharW-1:0]   cfg_data_i = '0;

  in_item_t         pending_items[$];
  out_item_t        expected_chars[$];
  logic [CharW-1:0] held_line[$];
  logic             held_trunc = 1'b0;
  logic [CharW-1:0] erase_code = EraseReset;
  logic [CharW-1:0] kill_code = KillReset;
  bit               calm = 1'b0;
  int               errors = 0;
  int unsigned      cycles = 0;

  line_editor_erase_kill #(.LINE_DEPTH(LineDepth)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Line editing as seen from outside: a flush expects the held line oldest first.
  function automatic void edit_line(in_item_t it);
    out_item_t r;
    if (it.in_end || it.in_char == NewlineCode) begin
      foreach (held_line[k]) begin
        r.out_char      = held_line[k];
        r.out_last      = (k == held_line.size() - 1);
        r.out_truncated = held_trunc;
        expected_chars.push_back(r);
      end
      held_line.delete();
      held_trunc = 1'b0;
    end else if (it.in_char == erase_code) begin
      if (held_line.size() > 0) void'(held_line.pop_back());
    end else if (it.in_char == kill_code) begin
      held_line.delete();
      held_trunc = 1'b0;
    end else if (held_line.size() >= LineDepth) begin
      held_trunc = 1'b1;
    end else begin
      held_line.push_back(it.in_char);
    end
  endfunction

  function automatic void queue_item(logic [CharW-1:0] c, logic e);
    in_item_t it;
    it.in_char = c;
    it.in_end  = e;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(s[i], 1'b0);
  endfunction

  // Mostly short lines with erase/kill noise, cut to the item budget;
  // a few left open so they run into the next line.
  task automatic queue_random_lines(int n_items);
    int count;
    int len;
    int pick;
    logic [CharW-1:0] c;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      len = (pick < 10) ? $urandom_range(72, 60) : $urandom_range(12, 0);
      if (len > n_items - count) len = n_items - count;
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(99);
        if (pick < 8) c = erase_code;
        else if (pick < 12) c = kill_code;
        else c = CharW'($urandom_range(255));
        queue_item(c, 1'b0);
        count++;
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        queue_item(NewlineCode, 1'b0);
        count++;
      end else if (pick < 95) begin
        queue_item(CharW'($urandom_range(255)), 1'b1);
        count++;
      end
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CharW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgEraseIdx) erase_code = val;
    else if (idx == CfgKillIdx) kill_code = val;
  endtask

  // Block is idle once every item is taken and every expected char has come out.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_chars.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) edit_line(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected item: out_char %0h", out_item_o.out_char);
          errors++;
        end else begin
          exp_item = expected_chars.pop_front();
          if (out_item_o.out_char !== exp_item.out_char) begin
            $error("out_char: expected %0h, got %0h", exp_item.out_char, out_item_o.out_char);
            errors++;
          end
          if (out_item_o.out_last !== exp_item.out_last) begin
            $error("out_last: expected %0b, got %0b", exp_item.out_last, out_item_o.out_last);
            errors++;
          end
          if (out_item_o.out_truncated !== exp_item.out_truncated) begin
            $error("out_truncated: expected %0b, got %0b",
                   exp_item.out_truncated, out_item_o.out_truncated);
            errors++;
          end
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset codes '#' and '@'
    queue_text("\n");
    queue_text("ab\n");
    queue_text("abc#d\n");
    queue_text("#x\n");
    queue_text("xy@z\n");
    queue_text("q");
    queue_item(8'hFF, 1'b1);            // end mark, its char ignored
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(NewlineCode, 1'b0);
    queue_item(NewlineCode, 1'b1);      // end mark on an empty line
    queue_random_lines(4);
    settle();

    // Extreme codes; out-of-range index must be ignored
    write_reg(CfgEraseIdx, 8'h00);
    write_reg(CfgKillIdx, 8'hFF);
    write_reg(UnusedIdx, 8'h41);
    calm = 1'b1;
    // overflow, then erase keeps the truncated flag
    for (int k = 0; k < 66; k++) queue_item(CharW'($urandom_range(254, 11)), 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(NewlineCode, 1'b0);
    // kill clears the line
    queue_text("a");
    queue_item(8'hFF, 1'b0);
    queue_text("b\n");
    queue_random_lines(2);
    settle();
    calm = 1'b0;

    // Same code for both: erase wins
    write_reg(CfgEraseIdx, 8'h55);
    write_reg(CfgKillIdx, 8'h55);
    queue_text("abU\n");
    queue_random_lines(2);
    settle();

    // Newline code in both registers: neither ever acts
    write_reg(CfgEraseIdx, NewlineCode);
    write_reg(CfgKillIdx, NewlineCode);
    queue_text("a\nb");
    queue_item(8'h00, 1'b1);
    queue_random_lines(2);
    settle();

    write_reg(CfgEraseIdx, 8'hFF);
    write_reg(CfgKillIdx, 8'h00);
    queue_random_lines(3);
    settle();

    write_reg(CfgEraseIdx, CharW'($urandom_range(255)));
    write_reg(CfgKillIdx, CharW'($urandom_range(255)));
    queue_random_lines(3);
    settle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
